@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros for the grid sampler, empty when assertions are off
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked on every rising edge outside of reset
`define GBS_ASSERT_RST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("assertion failed");

// checked on every rising edge, reset included
`define GBS_ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define GBS_ASSERT_RST(lbl, clk, rstn, prop)
`define GBS_ASSERT_CLK(lbl, clk, prop)

`endif

`endif

@@ rtl/gbs_pkg.sv @@
// ----------------------------------------------------------------------------
// gbs_pkg
// shared constants, codes and widths of the grid bilinear sampler
// ----------------------------------------------------------------------------
package gbs_pkg;

    // grid limits
    localparam int MAX_COLS    = 64;
    localparam int MAX_ROWS    = 64;
    localparam int STORE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // field widths
    localparam int CRD_W     = 32;
    localparam int EXT_W     = 31;
    localparam int DIM_W     = 7;
    localparam int VAL_W     = 17;
    localparam int FRAC_W    = 16;
    localparam int QUO_W     = EXT_W + FRAC_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    // cell index widths derived from the grid limits
    localparam int CX_W  = $clog2(MAX_COLS);
    localparam int CY_W  = $clog2(MAX_ROWS);
    localparam int NCX_W = $clog2(MAX_COLS + 1);
    localparam int NRY_W = $clog2(MAX_ROWS + 1);

    localparam logic [VAL_W-1:0] ONE_Q16 = VAL_W'(65536);

    // accepting edge to the edge that presents the result
    localparam int LATENCY = QUO_W + 6;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_EXTENT_X = 3'd2,
        CFG_EXTENT_Y = 3'd3,
        CFG_STEP_X   = 3'd4,
        CFG_STEP_Y   = 3'd5,
        CFG_COLS     = 3'd6,
        CFG_ROWS     = 3'd7
    } t_cfg_idx;

endpackage

@@ rtl/gbs_ram.sv @@
// ----------------------------------------------------------------------------
// gbs_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module gbs_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/grid_bilinear_sampler.sv @@
// ----------------------------------------------------------------------------
// grid_bilinear_sampler
// bilinear sampling of a loaded 2-d grid of q1.16 cells over a q16.16 area
// ----------------------------------------------------------------------------
// throughput: one transfer per cycle while busy is low, loads and samples mixed freely
// the two 47-step division pipelines (one quotient bit per stage) set the depth
// loads give no result; results come out in transfer order, never stalled
// reset restores the default configuration and clears all valid bits; busy is high for one cycle
// after reset, grid cells stay undefined until loaded
module grid_bilinear_sampler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_operation,
    input  logic [gbs_pkg::ADDR_W-1:0]    i_cell_index,
    input  logic [gbs_pkg::VAL_W-1:0]     i_cell_value,
    input  logic signed [gbs_pkg::CRD_W-1:0] i_point_x,
    input  logic signed [gbs_pkg::CRD_W-1:0] i_point_y,
    input  logic                          i_cfg_we,
    input  logic [gbs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [gbs_pkg::CFG_W-1:0]     i_cfg_wdata,
    output logic                          o_strobe,
    output logic                          o_inside_res,
    output logic [gbs_pkg::VAL_W-1:0]     o_sample
);

    `include "assert_macros.svh"

    // local width aliases
    localparam int ADDR_W = gbs_pkg::ADDR_W;
    localparam int CRD_W  = gbs_pkg::CRD_W;
    localparam int EXT_W  = gbs_pkg::EXT_W;
    localparam int VAL_W  = gbs_pkg::VAL_W;
    localparam int FRAC_W = gbs_pkg::FRAC_W;
    localparam int QW     = gbs_pkg::QUO_W;
    localparam int CX_W   = gbs_pkg::CX_W;
    localparam int CY_W   = gbs_pkg::CY_W;
    localparam int NCX_W  = gbs_pkg::NCX_W;
    localparam int NRY_W  = gbs_pkg::NRY_W;
    localparam int DIM_W  = gbs_pkg::DIM_W;
    localparam int PROD_W = CY_W + NCX_W + 1;   // row * cols + column
    localparam int OM_W   = FRAC_W + 1;         // one minus weight
    localparam int PA_W   = VAL_W + OM_W;       // cell * (1 - w)
    localparam int PC_W   = VAL_W + FRAC_W;     // cell * w
    localparam int LO_W   = PA_W + 1;           // blend along x
    localparam int PLO_W  = LO_W + OM_W;
    localparam int PUP_W  = LO_W + FRAC_W;
    localparam int TOT_W  = PLO_W + 1;
    localparam int RES_W  = TOT_W - 2 * FRAC_W;
    // accepting edge to the edge at which the result is taken
    localparam int RES_DLY = gbs_pkg::LATENCY + 1;

    // ---------------- pipeline stage records ----------------
    typedef struct packed {
        logic              valid;
        gbs_pkg::t_op      op;
        logic [ADDR_W-1:0] idx;
        logic [VAL_W-1:0]  val;
        logic [CRD_W-1:0]  px;
        logic [CRD_W-1:0]  py;
    } t_in_stg;

    typedef struct packed {
        logic              valid;
        gbs_pkg::t_op      op;
        logic              in_area;
        logic [ADDR_W-1:0] idx;
        logic [VAL_W-1:0]  val;
        logic [EXT_W-1:0]  lx;
        logic [EXT_W-1:0]  ly;
    } t_loc_stg;

    typedef struct packed {
        logic              valid;
        gbs_pkg::t_op      op;
        logic              in_area;
        logic [ADDR_W-1:0] idx;
        logic [VAL_W-1:0]  val;
        logic [EXT_W-1:0]  rx;
        logic [QW-1:0]     qx;
        logic [EXT_W-1:0]  ry;
        logic [QW-1:0]     qy;
    } t_dv_stg;

    typedef struct packed {
        logic [EXT_W-1:0] rem;
        logic [QW-1:0]    work;
    } t_dres;

    // lane order: 0 (y0,x0), 1 (y1,x0), 2 (y0,x1), 3 (y1,x1)
    typedef struct packed {
        logic                   valid;
        gbs_pkg::t_op           op;
        logic                   in_area;
        logic [ADDR_W-1:0]      idx;
        logic [VAL_W-1:0]       val;
        logic [3:0][ADDR_W-1:0] raddr;
        logic [FRAC_W-1:0]      wx;
        logic [FRAC_W-1:0]      wy;
    } t_ad_stg;

    typedef struct packed {
        logic              valid;
        logic              in_area;
        logic [FRAC_W-1:0] wx;
        logic [FRAC_W-1:0] wy;
    } t_rd_stg;

    typedef struct packed {
        logic              valid;
        logic              in_area;
        logic [FRAC_W-1:0] wy;
        logic [PA_W-1:0]   pa;
        logic [PA_W-1:0]   pb;
        logic [PC_W-1:0]   pc;
        logic [PC_W-1:0]   pd;
    } t_m1_stg;

    typedef struct packed {
        logic             valid;
        logic             in_area;
        logic [PLO_W-1:0] plo;
        logic [PUP_W-1:0] pup;
    } t_m2_stg;

    // one restoring division step: shift in a numerator bit, subtract if it fits
    function automatic t_dres div_step(input logic [EXT_W-1:0] rem,
                                       input logic [QW-1:0]    work,
                                       input logic [EXT_W-1:0] dvs);
        logic [EXT_W:0] t;
        logic           qbit;
        t_dres          r;
        t    = {rem, work[QW-1]};
        qbit = (t >= {1'b0, dvs});
        if (qbit) begin
            t = t - {1'b0, dvs};
        end
        r.rem  = t[EXT_W-1:0];
        r.work = {work[QW-2:0], qbit};
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [CY_W-1:0]  y,
                                                    input logic [CX_W-1:0]  x,
                                                    input logic [NCX_W-1:0] nc);
        logic [PROD_W-1:0] s;
        s = PROD_W'(y) * PROD_W'(nc) + PROD_W'(x);
        return ADDR_W'(s);
    endfunction

    // ---------------- configuration registers ----------------
    logic signed [CRD_W-1:0] r_org_x, r_org_y;
    logic [EXT_W-1:0]        r_ext_x, r_ext_y;
    logic [EXT_W-1:0]        r_step_x, r_step_y;
    logic [DIM_W-1:0]        r_cols, r_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x  <= '0;
            r_org_y  <= '0;
            r_ext_x  <= '0;
            r_ext_y  <= '0;
            r_step_x <= EXT_W'(65536);
            r_step_y <= EXT_W'(65536);
            r_cols   <= DIM_W'(64);
            r_rows   <= DIM_W'(64);
        end else if (i_cfg_we) begin
            case (gbs_pkg::t_cfg_idx'(i_cfg_idx))
                gbs_pkg::CFG_ORIGIN_X: r_org_x  <= $signed(i_cfg_wdata);
                gbs_pkg::CFG_ORIGIN_Y: r_org_y  <= $signed(i_cfg_wdata);
                gbs_pkg::CFG_EXTENT_X: r_ext_x  <= i_cfg_wdata[EXT_W-1:0];
                gbs_pkg::CFG_EXTENT_Y: r_ext_y  <= i_cfg_wdata[EXT_W-1:0];
                gbs_pkg::CFG_STEP_X:   r_step_x <= i_cfg_wdata[EXT_W-1:0];
                gbs_pkg::CFG_STEP_Y:   r_step_y <= i_cfg_wdata[EXT_W-1:0];
                gbs_pkg::CFG_COLS:     r_cols   <= i_cfg_wdata[DIM_W-1:0];
                gbs_pkg::CFG_ROWS:     r_rows   <= i_cfg_wdata[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // effective step (zero acts as one lsb) and clamped grid size; the user must
    // change configuration only while idle, which the block does not enforce; every stage reads these directly
    logic [EXT_W-1:0] sx, sy;
    logic [NCX_W-1:0] nc;
    logic [NRY_W-1:0] nr;
    logic [CX_W-1:0]  last_x;
    logic [CY_W-1:0]  last_y;

    always_comb begin
        sx = (r_step_x == '0) ? EXT_W'(1) : r_step_x;
        sy = (r_step_y == '0) ? EXT_W'(1) : r_step_y;
        if (r_cols == '0) begin
            nc = NCX_W'(1);
        end else if (int'(r_cols) > gbs_pkg::MAX_COLS) begin
            nc = NCX_W'(gbs_pkg::MAX_COLS);
        end else begin
            nc = NCX_W'(r_cols);
        end
        if (r_rows == '0) begin
            nr = NRY_W'(1);
        end else if (int'(r_rows) > gbs_pkg::MAX_ROWS) begin
            nr = NRY_W'(gbs_pkg::MAX_ROWS);
        end else begin
            nr = NRY_W'(r_rows);
        end
        last_x = CX_W'(nc - NCX_W'(1));
        last_y = CY_W'(nr - NRY_W'(1));
    end

    // ---------------- busy: held for one cycle after reset ----------------
    logic r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy = r_busy;

    logic accept;
    assign accept = start && !r_busy;

    // ---------------- stage: input capture ----------------
    t_in_stg r_in, n_in;

    always_comb begin
        n_in.valid = accept;
        n_in.op    = gbs_pkg::t_op'(i_operation);
        n_in.idx   = i_cell_index;
        n_in.val   = i_cell_value;
        n_in.px    = i_point_x;
        n_in.py    = i_point_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else begin
            r_in <= n_in;
        end
    end

    // ---------------- stage: containment test and local coordinates ----------------
    t_loc_stg r_loc, n_loc;
    logic signed [CRD_W+1:0] px_w, py_w, ox_w, oy_w, hx_w, hy_w;

    always_comb begin
        px_w = (CRD_W+2)'($signed(r_in.px));
        py_w = (CRD_W+2)'($signed(r_in.py));
        ox_w = (CRD_W+2)'(r_org_x);
        oy_w = (CRD_W+2)'(r_org_y);
        hx_w = ox_w + $signed((CRD_W+2)'(r_ext_x));
        hy_w = oy_w + $signed((CRD_W+2)'(r_ext_y));

        n_loc.valid   = r_in.valid;
        n_loc.op      = r_in.op;
        n_loc.idx     = r_in.idx;
        n_loc.val     = r_in.val;
        // closed area on both axes
        n_loc.in_area = (px_w >= ox_w) && (px_w <= hx_w) &&
                        (py_w >= oy_w) && (py_w <= hy_w);
        // inside the area the offset is never above the extent
        n_loc.lx      = EXT_W'(r_in.px - r_org_x);
        n_loc.ly      = EXT_W'(r_in.py - r_org_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loc.valid <= 1'b0;
        end else begin
            r_loc <= n_loc;
        end
    end

    // ---------------- stages: division by the cell step ----------------
    // quotient of (local << 16) / step: upper bits are the floor cell,
    // the low 16 bits the fraction; one quotient bit per stage
    t_dv_stg r_dv [QW];
    t_dv_stg n_dv [QW];

    always_comb begin
        t_dv_stg src;
        t_dres   sx_r, sy_r;
        for (int k = 0; k < QW; k++) begin
            if (k == 0) begin
                src.valid   = r_loc.valid;
                src.op      = r_loc.op;
                src.in_area = r_loc.in_area;
                src.idx     = r_loc.idx;
                src.val     = r_loc.val;
                src.rx      = '0;
                src.qx      = {r_loc.lx, FRAC_W'(0)};
                src.ry      = '0;
                src.qy      = {r_loc.ly, FRAC_W'(0)};
            end else begin
                src = r_dv[k-1];
            end
            sx_r     = div_step(src.rx, src.qx, sx);
            sy_r     = div_step(src.ry, src.qy, sy);
            n_dv[k]  = src;
            n_dv[k].rx = sx_r.rem;
            n_dv[k].qx = sx_r.work;
            n_dv[k].ry = sy_r.rem;
            n_dv[k].qy = sy_r.work;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QW; k++) begin
            if (!i_rst_n) begin
                r_dv[k].valid <= 1'b0;
            end else begin
                r_dv[k] <= n_dv[k];
            end
        end
    end

    // ---------------- stage: cell clamp, weights, addresses ----------------
    t_ad_stg r_ad, n_ad;
    logic [EXT_W-1:0]  ip_x, ip_y;
    logic [FRAC_W-1:0] fr_x, fr_y;
    logic [EXT_W:0]    ce_x, ce_y;
    logic [CX_W-1:0]   x0, x1;
    logic [CY_W-1:0]   y0, y1;

    always_comb begin
        ip_x = r_dv[QW-1].qx[QW-1:FRAC_W];
        fr_x = r_dv[QW-1].qx[FRAC_W-1:0];
        ip_y = r_dv[QW-1].qy[QW-1:FRAC_W];
        fr_y = r_dv[QW-1].qy[FRAC_W-1:0];

        // floor cell, clamped to the last column / row
        x0 = (ip_x > EXT_W'(last_x)) ? last_x : ip_x[CX_W-1:0];
        y0 = (ip_y > EXT_W'(last_y)) ? last_y : ip_y[CY_W-1:0];

        // ceil cell, clamped the same way
        ce_x = {1'b0, ip_x} + (EXT_W+1)'(fr_x != '0);
        ce_y = {1'b0, ip_y} + (EXT_W+1)'(fr_y != '0);
        x1 = (ce_x > (EXT_W+1)'(last_x)) ? last_x : ce_x[CX_W-1:0];
        y1 = (ce_y > (EXT_W+1)'(last_y)) ? last_y : ce_y[CY_W-1:0];

        n_ad.valid    = r_dv[QW-1].valid;
        n_ad.op       = r_dv[QW-1].op;
        n_ad.in_area  = r_dv[QW-1].in_area;
        n_ad.idx      = r_dv[QW-1].idx;
        n_ad.val      = r_dv[QW-1].val;
        // no blend when both neighbors collapse onto one cell
        n_ad.wx       = (x1 != x0) ? fr_x : '0;
        n_ad.wy       = (y1 != y0) ? fr_y : '0;
        n_ad.raddr[0] = cell_addr(y0, x0, nc);
        n_ad.raddr[1] = cell_addr(y1, x0, nc);
        n_ad.raddr[2] = cell_addr(y0, x1, nc);
        n_ad.raddr[3] = cell_addr(y1, x1, nc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ad.valid <= 1'b0;
        end else begin
            r_ad <= n_ad;
        end
    end

    // ---------------- grid store: four copies, one read lane each ----------------
    // loads are written at the same stage where samples read, so every sample
    // sees exactly the loads transferred before it
    logic                ram_we;
    logic [VAL_W-1:0]    rd_data [4];

    assign ram_we = r_ad.valid && (r_ad.op == gbs_pkg::OP_LOAD);

    for (genvar g = 0; g < 4; g++) begin : g_lane
        gbs_ram #(
            .WIDTH (VAL_W),
            .DEPTH (gbs_pkg::STORE_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (ram_we),
            .i_waddr (r_ad.idx),
            .i_wdata (r_ad.val),
            .i_raddr (r_ad.raddr[g]),
            .o_rdata (rd_data[g])
        );
    end

    // ---------------- stage: read data alignment ----------------
    t_rd_stg r_rd, n_rd;

    always_comb begin
        n_rd.valid   = r_ad.valid && (r_ad.op == gbs_pkg::OP_SAMPLE);
        n_rd.in_area = r_ad.in_area;
        n_rd.wx      = r_ad.wx;
        n_rd.wy      = r_ad.wy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd.valid <= 1'b0;
        end else begin
            r_rd <= n_rd;
        end
    end

    // ---------------- stage: x weight products ----------------
    t_m1_stg        r_m1, n_m1;
    logic [OM_W-1:0] omx;

    always_comb begin
        omx          = gbs_pkg::ONE_Q16 - OM_W'(r_rd.wx);
        n_m1.valid   = r_rd.valid;
        n_m1.in_area = r_rd.in_area;
        n_m1.wy      = r_rd.wy;
        n_m1.pa      = PA_W'(rd_data[0]) * PA_W'(omx);
        n_m1.pb      = PA_W'(rd_data[1]) * PA_W'(omx);
        n_m1.pc      = PC_W'(rd_data[2]) * PC_W'(r_rd.wx);
        n_m1.pd      = PC_W'(rd_data[3]) * PC_W'(r_rd.wx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1.valid <= 1'b0;
        end else begin
            r_m1 <= n_m1;
        end
    end

    // ---------------- stage: x blend sums and y weight products ----------------
    t_m2_stg         r_m2, n_m2;
    logic [OM_W-1:0] omy;
    logic [LO_W-1:0] lo_sum, up_sum;

    always_comb begin
        omy          = gbs_pkg::ONE_Q16 - OM_W'(r_m1.wy);
        lo_sum       = LO_W'(r_m1.pa) + LO_W'(r_m1.pc);
        up_sum       = LO_W'(r_m1.pb) + LO_W'(r_m1.pd);
        n_m2.valid   = r_m1.valid;
        n_m2.in_area = r_m1.in_area;
        n_m2.plo     = PLO_W'(lo_sum) * PLO_W'(omy);
        n_m2.pup     = PUP_W'(up_sum) * PUP_W'(r_m1.wy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2.valid <= 1'b0;
        end else begin
            r_m2 <= n_m2;
        end
    end

    // ---------------- stage: round half up, saturate, present ----------------
    logic [TOT_W-1:0] total;
    logic [RES_W-1:0] res;
    logic [VAL_W-1:0] sat;
    logic             r_out_vld;
    logic             r_out_inside;
    logic [VAL_W-1:0] r_out_sample;

    always_comb begin
        total = TOT_W'(r_m2.plo) + TOT_W'(r_m2.pup) + (TOT_W'(1) << (2 * FRAC_W - 1));
        res   = total[TOT_W-1:2*FRAC_W];
        sat   = (res > RES_W'(gbs_pkg::ONE_Q16)) ? gbs_pkg::ONE_Q16 : VAL_W'(res);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_m2.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_inside <= r_m2.in_area;
        r_out_sample <= r_m2.in_area ? sat : '0;
    end

    assign o_strobe     = r_out_vld;
    assign o_inside_res = r_out_inside;
    assign o_sample     = r_out_sample;

    // ---------------- assertions ----------------
    // sample transfer seen at the accepting edge
    logic smp_acc;
    assign smp_acc = accept && (gbs_pkg::t_op'(i_operation) == gbs_pkg::OP_SAMPLE);

    // every result traces back to a sample transfer a fixed latency earlier
    `GBS_ASSERT_RST(a_result_from_sample, i_clk, i_rst_n, o_strobe |-> $past(smp_acc, RES_DLY))
    // a point outside the area never carries a value
    `GBS_ASSERT_RST(a_outside_zero, i_clk, i_rst_n, o_strobe && !o_inside_res |-> o_sample == '0)
    // interpolated value stays within one
    `GBS_ASSERT_RST(a_sample_sat, i_clk, i_rst_n, o_strobe |-> o_sample <= gbs_pkg::ONE_Q16)
    // reset flushes the pipe and holds off the next transfer
    `GBS_ASSERT_CLK(a_reset_flush, i_clk, !i_rst_n |=> busy && !o_strobe)

endmodule
